/* sv/bfsp_pkg.sv */
`timescale 1ns / 1ps

package bfsp_pkg;

  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF = 1024;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned COST_W = 16;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned PRED_W = NODE_W + 1;

  localparam int unsigned EDGE_ENTRY_W = 2 * NODE_W + COST_W;
  localparam int unsigned NODE_ENTRY_W = 1 + PRED_W + DIST_W;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(64);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_SRC,
    S_EREAD,
    S_FREAD,
    S_TREAD,
    S_CAND,
    S_CMP,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [COST_W-1:0] cost;
  } edge_t;

  typedef struct packed {
    logic              reach;
    logic [PRED_W-1:0] pred;
    logic [DIST_W-1:0] path_dist;
  } node_t;

endpackage

/* sv/bfsp_ram.sv */
`timescale 1ns / 1ps

module bfsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bellman_ford_shortest_paths_unit.sv */
`timescale 1ns / 1ps
// Single-source shortest paths over a stored edge list, by repeated relaxation.
// A request is taken when start is high and busy is low. Func add appends an edge
// (dropped once the edge store is full) and func clear empties the list; for
// both busy stays low, so edges load at one per cycle.
// Func run raises busy and clears the whole node store, seeds the source when it
// is below n, then makes n-1 relaxing passes and one checking pass over the
// edges, where n is node_count clamped to 1..MAX_NODES. An edge visit with an
// endpoint out of range passes S_EREAD, S_FREAD and S_NEXT; one whose tail is not
// yet reached also passes S_TREAD, and any other also S_CAND and S_CMP. The one
// node store read port serves both endpoint reads in turn.
// Each node is then read out in S_EMIT_RD and S_EMIT_OUT, and its result
// appears for one cycle with result_valid_o high; last_o marks node n-1. The
// receiver cannot stall, so results are never held back. Busy falls in the
// cycle that shows the last result. Reset empties the edge list and sets
// node_count to 64. The user must see that node_count is written with
// node_count_we_i only while the block is idle; the block does not enforce it.

module bellman_ford_shortest_paths_unit #(
  parameter int unsigned MAX_NODES = bfsp_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = bfsp_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfsp_pkg::FUNC_W-1:0]   func_i,
  input  logic [bfsp_pkg::NODE_W-1:0]   edge_from_i,
  input  logic [bfsp_pkg::NODE_W-1:0]   edge_to_i,
  input  logic signed [bfsp_pkg::COST_W-1:0] edge_cost_i,
  input  logic [bfsp_pkg::NODE_W-1:0]   source_node_i,
  input  logic                          node_count_we_i,
  input  logic [bfsp_pkg::CFG_W-1:0]    node_count_i,
  output logic                          result_valid_o,
  output logic [bfsp_pkg::NODE_W-1:0]   node_index_o,
  output logic                          reachable_o,
  output logic signed [bfsp_pkg::DIST_W-1:0] distance_o,
  output logic                          has_pred_o,
  output logic [bfsp_pkg::NODE_W-1:0]   pred_node_o,
  output logic                          negative_cycle_o,
  output logic                          last_o
);

  import bfsp_pkg::*;

  localparam int unsigned NAW = $clog2(MAX_NODES);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ETW = $clog2(MAX_EDGES + 1);
  localparam logic [CFG_W-1:0] N_MAX  = CFG_W'(MAX_NODES);
  localparam logic [ETW-1:0]   E_MAX  = ETW'(MAX_EDGES);
  localparam logic [DIST_W:0]  SAT_HI = {2'b00, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W:0]  SAT_LO = {2'b11, {(DIST_W-1){1'b0}}};

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  node_count_q;
  logic [CFG_W-1:0]  n_q, n_d;
  logic [NODE_W-1:0] src_q, src_d;
  logic [ETW-1:0]    total_q, total_d;
  logic [ETW-1:0]    e_q, e_d;
  logic [CFG_W-1:0]  p_q, p_d;
  logic [CFG_W-1:0]  i_q, i_d;
  logic              neg_q, neg_d;
  logic [DIST_W-1:0] distf_q, distf_d;
  logic [DIST_W-1:0] cand_q, cand_d;

  logic              res_valid_q, res_valid_d;
  node_t             res_node_q, res_node_d;
  logic [NODE_W-1:0] res_idx_q, res_idx_d;
  logic              res_neg_q, res_neg_d;
  logic              res_last_q, res_last_d;

  logic              edge_we;
  edge_t             edge_wdata;
  logic              edge_re;
  logic [EDGE_ENTRY_W-1:0] edge_rdata;
  edge_t             edge_rd;

  logic              node_we;
  logic [NAW-1:0]    node_waddr;
  node_t             node_wdata;
  logic              node_re;
  logic [NAW-1:0]    node_raddr;
  logic [NODE_ENTRY_W-1:0] node_rdata;
  node_t             node_rd;

  logic [CFG_W-1:0]  n_clamp;
  logic [DIST_W:0]   sum;
  logic              apply;
  logic              accept;

  assign edge_rd = edge_t'(edge_rdata);
  assign node_rd = node_t'(node_rdata);
  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign apply   = (p_q != n_q - CFG_W'(1));

  assign n_clamp = (node_count_q == '0) ? CFG_W'(1) :
                   (node_count_q > N_MAX) ? N_MAX : node_count_q;

  assign sum = {distf_q[DIST_W-1], distf_q} +
               {{(DIST_W+1-COST_W){edge_rd.cost[COST_W-1]}}, edge_rd.cost};

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    src_d      = src_q;
    total_d    = total_q;
    e_d        = e_q;
    p_d        = p_q;
    i_d        = i_q;
    neg_d      = neg_q;
    distf_d    = distf_q;
    cand_d     = cand_q;
    res_valid_d = 1'b0;
    res_node_d = res_node_q;
    res_idx_d  = res_idx_q;
    res_neg_d  = res_neg_q;
    res_last_d = res_last_q;

    edge_we    = 1'b0;
    edge_wdata = '{from_node: edge_from_i, to_node: edge_to_i, cost: edge_cost_i};
    edge_re    = 1'b0;
    node_we    = 1'b0;
    node_waddr = i_q[NAW-1:0];
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = i_q[NAW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_ADD: begin
              if (total_q < E_MAX) begin
                edge_we = 1'b1;
                total_d = total_q + ETW'(1);
              end
            end
            FUNC_CLEAR: begin
              total_d = '0;
            end
            FUNC_RUN: begin
              n_d     = n_clamp;
              src_d   = source_node_i;
              i_d     = '0;
              neg_d   = 1'b0;
              state_d = S_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLR: begin
        node_we = 1'b1;
        if (i_q == N_MAX - CFG_W'(1)) begin
          state_d = S_SRC;
        end else begin
          i_d = i_q + CFG_W'(1);
        end
      end
      S_SRC: begin
        if ({1'b0, src_q} < n_q) begin
          node_we    = 1'b1;
          node_waddr = src_q[NAW-1:0];
          node_wdata = '{reach: 1'b1, pred: '0, path_dist: '0};
        end
        e_d = '0;
        p_d = '0;
        i_d = '0;
        state_d = (total_q == '0) ? S_EMIT_RD : S_EREAD;
      end
      S_EREAD: begin
        edge_re = 1'b1;
        state_d = S_FREAD;
      end
      S_FREAD: begin
        if (({1'b0, edge_rd.from_node} < n_q) && ({1'b0, edge_rd.to_node} < n_q)) begin
          node_re    = 1'b1;
          node_raddr = edge_rd.from_node[NAW-1:0];
          state_d    = S_TREAD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_TREAD: begin
        distf_d = node_rd.path_dist;
        if (node_rd.reach) begin
          node_re    = 1'b1;
          node_raddr = edge_rd.to_node[NAW-1:0];
          state_d    = S_CAND;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_CAND: begin
        if (sum[DIST_W] != sum[DIST_W-1]) begin
          cand_d = sum[DIST_W] ? SAT_LO[DIST_W-1:0] : SAT_HI[DIST_W-1:0];
        end else begin
          cand_d = sum[DIST_W-1:0];
        end
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!node_rd.reach || ($signed(node_rd.path_dist) > $signed(cand_q))) begin
          if (apply) begin
            node_we    = 1'b1;
            node_waddr = edge_rd.to_node[NAW-1:0];
            node_wdata = '{reach: 1'b1, pred: {1'b1, edge_rd.from_node},
                           path_dist: cand_q};
          end else begin
            neg_d = 1'b1;
          end
        end
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (e_q == total_q - ETW'(1)) begin
          e_d = '0;
          if (!apply) begin
            i_d     = '0;
            state_d = S_EMIT_RD;
          end else begin
            p_d     = p_q + CFG_W'(1);
            state_d = S_EREAD;
          end
        end else begin
          e_d     = e_q + ETW'(1);
          state_d = S_EREAD;
        end
      end
      S_EMIT_RD: begin
        node_re = 1'b1;
        state_d = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        res_valid_d = 1'b1;
        res_node_d  = node_rd;
        res_idx_d   = i_q[NODE_W-1:0];
        res_neg_d   = neg_q;
        res_last_d  = (i_q == n_q - CFG_W'(1));
        if (i_q == n_q - CFG_W'(1)) begin
          state_d = S_IDLE;
        end else begin
          i_d     = i_q + CFG_W'(1);
          state_d = S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NODE_COUNT_RESET;
      total_q      <= '0;
      res_valid_q  <= 1'b0;
      n_q          <= CFG_W'(1);
      e_q          <= '0;
      p_q          <= '0;
      i_q          <= '0;
      neg_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
      n_q         <= n_d;
      e_q         <= e_d;
      p_q         <= p_d;
      i_q         <= i_d;
      neg_q       <= neg_d;
      if (node_count_we_i) begin
        node_count_q <= node_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    distf_q    <= distf_d;
    cand_q     <= cand_d;
    res_node_q <= res_node_d;
    res_idx_q  <= res_idx_d;
    res_neg_q  <= res_neg_d;
    res_last_q <= res_last_d;
  end

  bfsp_ram #(
    .WIDTH(EDGE_ENTRY_W),
    .DEPTH(MAX_EDGES)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(total_q[EAW-1:0]),
    .wdata_i(edge_wdata),
    .re_i   (edge_re),
    .raddr_i(e_q[EAW-1:0]),
    .rdata_o(edge_rdata)
  );

  bfsp_ram #(
    .WIDTH(NODE_ENTRY_W),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .re_i   (node_re),
    .raddr_i(node_raddr),
    .rdata_o(node_rdata)
  );

  assign result_valid_o   = res_valid_q;
  assign node_index_o     = res_idx_q;
  assign reachable_o      = res_node_q.reach;
  assign distance_o       = res_node_q.path_dist;
  assign has_pred_o       = res_node_q.pred[PRED_W-1];
  assign pred_node_o      = res_node_q.pred[NODE_W-1:0];
  assign negative_cycle_o = res_neg_q;
  assign last_o           = res_last_q;

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == S_EMIT_OUT))
    else $error("result strobe without a node readout");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_last_q) |-> (state_q == S_IDLE))
    else $error("run still busy after its last result");

  a_node_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_we |-> busy)
    else $error("node store written while idle");

  a_edge_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_we |-> (!busy && (total_q < E_MAX)))
    else $error("edge store written while busy or full");

  a_edge_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_we |=> (total_q == $past(total_q) + ETW'(1)))
    else $error("edge count did not follow an edge write");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bfsp_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam longint DIST_MAX = 64'sd2147483647;
  localparam longint DIST_MIN = -64'sd2147483648;

  typedef struct {
    logic [NODE_W-1:0]        node;
    logic                     reach;
    logic signed [DIST_W-1:0] path_dist;
    logic                     has_pred;
    logic [NODE_W-1:0]        pred;
    logic                     neg;
    logic                     last;
  } node_report_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [FUNC_W-1:0]        func_i;
  logic [NODE_W-1:0]        edge_from_i;
  logic [NODE_W-1:0]        edge_to_i;
  logic signed [COST_W-1:0] edge_cost_i;
  logic [NODE_W-1:0]        source_node_i;
  logic                     node_count_we_i;
  logic [CFG_W-1:0]         node_count_i;
  logic                     result_valid_o;
  logic [NODE_W-1:0]        node_index_o;
  logic                     reachable_o;
  logic signed [DIST_W-1:0] distance_o;
  logic                     has_pred_o;
  logic [NODE_W-1:0]        pred_node_o;
  logic                     negative_cycle_o;
  logic                     last_o;

  logic [NODE_W-1:0]        edge_from_list [MAX_EDGES_DEF];
  logic [NODE_W-1:0]        edge_to_list [MAX_EDGES_DEF];
  logic signed [COST_W-1:0] edge_cost_list [MAX_EDGES_DEF];
  int                       edge_count;
  logic [CFG_W-1:0]         nodes_in_use;
  node_report_t             expected_nodes [$];

  int sender_idle_pct;
  int error_count;
  int requests_accepted;
  int runs_accepted;
  int reports_checked;
  int settings_written;

  bellman_ford_shortest_paths_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .edge_from_i      (edge_from_i),
    .edge_to_i        (edge_to_i),
    .edge_cost_i      (edge_cost_i),
    .source_node_i    (source_node_i),
    .node_count_we_i  (node_count_we_i),
    .node_count_i     (node_count_i),
    .result_valid_o   (result_valid_o),
    .node_index_o     (node_index_o),
    .reachable_o      (reachable_o),
    .distance_o       (distance_o),
    .has_pred_o       (has_pred_o),
    .pred_node_o      (pred_node_o),
    .negative_cycle_o (negative_cycle_o),
    .last_o           (last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("tb: error: %0s", msg);
    end
  endfunction

  function automatic string describe_report(input node_report_t r);
    return $sformatf("node %0d reach %0b dist %0d pred %0b/%0d neg %0b last %0b",
                     r.node, r.reach, r.path_dist, r.has_pred, r.pred, r.neg, r.last);
  endfunction

  function automatic void solve_paths(input logic [NODE_W-1:0] src);
    int           n;
    int           f;
    int           t;
    int           cand;
    longint       sum;
    bit           neg;
    int           node_dist [MAX_NODES_DEF];
    bit           reach [MAX_NODES_DEF];
    bit           has_pred [MAX_NODES_DEF];
    int           pred [MAX_NODES_DEF];
    node_report_t rep;
    n = int'(nodes_in_use);
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_NODES_DEF) begin
      n = MAX_NODES_DEF;
    end
    neg = 1'b0;
    for (int i = 0; i < MAX_NODES_DEF; i++) begin
      node_dist[i] = 0;
      reach[i] = 1'b0;
      has_pred[i] = 1'b0;
      pred[i] = 0;
    end
    if (int'(src) < n) begin
      reach[src] = 1'b1;
    end
    // The last pass only looks for an edge that still relaxes.
    for (int p = 0; p < n; p++) begin
      for (int e = 0; e < edge_count; e++) begin
        f = int'(edge_from_list[e]);
        t = int'(edge_to_list[e]);
        if (f < n && t < n && reach[f]) begin
          sum = longint'(node_dist[f]) + longint'(edge_cost_list[e]);
          if (sum > DIST_MAX) begin
            cand = int'(DIST_MAX);
          end else if (sum < DIST_MIN) begin
            cand = int'(DIST_MIN);
          end else begin
            cand = int'(sum);
          end
          if (!reach[t] || node_dist[t] > cand) begin
            if (p == n - 1) begin
              neg = 1'b1;
            end else begin
              node_dist[t] = cand;
              reach[t] = 1'b1;
              has_pred[t] = 1'b1;
              pred[t] = f;
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      rep.node = NODE_W'(i);
      rep.reach = reach[i];
      rep.path_dist = reach[i] ? node_dist[i] : 0;
      rep.has_pred = has_pred[i];
      rep.pred = has_pred[i] ? NODE_W'(pred[i]) : '0;
      rep.neg = neg;
      rep.last = (i == n - 1);
      expected_nodes.push_back(rep);
    end
  endfunction

  function automatic void apply_request(input logic [FUNC_W-1:0] f,
                                        input logic [NODE_W-1:0] from_n,
                                        input logic [NODE_W-1:0] to_n,
                                        input logic signed [COST_W-1:0] cost,
                                        input logic [NODE_W-1:0] src);
    requests_accepted++;
    case (f)
      FUNC_ADD: begin
        if (edge_count < MAX_EDGES_DEF) begin
          edge_from_list[edge_count] = from_n;
          edge_to_list[edge_count] = to_n;
          edge_cost_list[edge_count] = cost;
          edge_count++;
        end
      end
      FUNC_CLEAR: begin
        edge_count = 0;
      end
      FUNC_RUN: begin
        runs_accepted++;
        solve_paths(src);
      end
      default: begin
      end
    endcase
  endfunction

  // The request stays on the bus until busy is low at a rising edge.
  task automatic send_request(input logic [FUNC_W-1:0] f,
                              input logic [NODE_W-1:0] from_n,
                              input logic [NODE_W-1:0] to_n,
                              input logic signed [COST_W-1:0] cost,
                              input logic [NODE_W-1:0] src);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    edge_from_i <= from_n;
    edge_to_i <= to_n;
    edge_cost_i <= cost;
    source_node_i <= src;
    do @(posedge clk_i); while (busy);
    apply_request(f, from_n, to_n, cost, src);
  endtask

  task automatic drain_results();
    if (expected_nodes.size() != 0) begin
      start <= 1'b0;
      do @(posedge clk_i); while (expected_nodes.size() != 0);
    end
  endtask

  task automatic set_node_count(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (expected_nodes.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    node_count_we_i <= 1'b1;
    node_count_i <= value;
    @(posedge clk_i);
    node_count_we_i <= 1'b0;
    nodes_in_use = value;
    settings_written++;
  endtask

  function automatic logic [NODE_W-1:0] random_node(input int n);
    if ($urandom_range(0, 4) == 0) begin
      return NODE_W'($urandom_range(0, 63));
    end
    return NODE_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic signed [COST_W-1:0] random_cost();
    int c;
    if ($urandom_range(0, 3) == 0) begin
      c = $urandom;
    end else begin
      c = $urandom_range(0, 60) - 12;
    end
    return COST_W'(c);
  endfunction

  task automatic test_small_graph();
    set_node_count(7'd4);
    send_request(FUNC_CLEAR, '0, '0, '0, '0);
    send_request(FUNC_ADD, 6'd0, 6'd1, 16'sd5, '0);
    send_request(FUNC_ADD, 6'd1, 6'd2, -16'sd3, '0);
    send_request(FUNC_ADD, 6'd0, 6'd2, 16'sd4, '0);
    send_request(FUNC_ADD, 6'd2, 6'd3, 16'sd32767, '0);
    send_request(FUNC_ADD, 6'd3, 6'd0, 16'sh8000, '0);
    send_request(FUNC_ADD, 6'd0, 6'd63, 16'sd1, '0);
    send_request(FUNC_UNUSED, 6'd63, 6'd63, -16'sd1, 6'd63);
    send_request(FUNC_RUN, '0, '0, '0, 6'd0);
    send_request(FUNC_RUN, '0, '0, '0, 6'd63);
  endtask

  task automatic test_negative_cycle();
    send_request(FUNC_CLEAR, '0, '0, '0, '0);
    send_request(FUNC_ADD, 6'd0, 6'd1, 16'sd2, '0);
    send_request(FUNC_ADD, 6'd1, 6'd2, -16'sd7, '0);
    send_request(FUNC_ADD, 6'd2, 6'd1, 16'sd3, '0);
    send_request(FUNC_RUN, '0, '0, '0, 6'd0);
    send_request(FUNC_RUN, '0, '0, '0, 6'd3);
  endtask

  task automatic test_node_count_limits();
    set_node_count(7'd0);
    send_request(FUNC_RUN, '0, '0, '0, 6'd0);
    send_request(FUNC_RUN, '0, '0, '0, 6'd1);
    set_node_count(7'd127);
    send_request(FUNC_CLEAR, '0, '0, '0, '0);
    send_request(FUNC_ADD, 6'd63, 6'd0, -16'sd1, '0);
    send_request(FUNC_ADD, 6'd0, 6'd63, 16'sh8000, '0);
    send_request(FUNC_RUN, '0, '0, '0, 6'd63);
    set_node_count(7'd64);
    send_request(FUNC_RUN, '0, '0, '0, 6'd0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int item_goal,
                                     input int max_pick);
    int sent;
    int n;
    sender_idle_pct = idle_pct;
    set_node_count(CFG_W'($urandom_range(2, max_pick)));
    n = int'(nodes_in_use);
    sent = 0;
    while (sent < item_goal) begin
      if (edge_count > 40 || $urandom_range(0, 7) == 0) begin
        send_request(FUNC_CLEAR, random_node(n), random_node(n), random_cost(),
                     random_node(n));
        sent++;
      end
      repeat ($urandom_range(1, 8)) begin
        send_request(FUNC_ADD, random_node(n), random_node(n), random_cost(),
                     random_node(n));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_request(FUNC_UNUSED, random_node(n), random_node(n), random_cost(),
                     random_node(n));
      end
      if ($urandom_range(0, 9) != 0) begin
        send_request(FUNC_RUN, random_node(n), random_node(n), random_cost(),
                     random_node(n));
        sent++;
      end
      if ($urandom_range(0, 14) == 0) begin
        drain_results();
      end
    end
  endtask

  always @(posedge clk_i) begin : report_check
    node_report_t want;
    node_report_t got;
    if (rst_ni && result_valid_o) begin
      got = '{node_index_o, reachable_o, distance_o, has_pred_o, pred_node_o,
              negative_cycle_o, last_o};
      reports_checked++;
      if (expected_nodes.size() == 0) begin
        note_error($sformatf("report with no run pending: %0s", describe_report(got)));
      end else begin
        want = expected_nodes.pop_front();
        if (got.node !== want.node || got.reach !== want.reach ||
            got.path_dist !== want.path_dist || got.has_pred !== want.has_pred ||
            got.pred !== want.pred || got.neg !== want.neg || got.last !== want.last) begin
          note_error($sformatf("expected %0s, got %0s", describe_report(want),
                               describe_report(got)));
        end
      end
    end
  end

  initial begin
    #25_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    func_i <= FUNC_ADD;
    edge_from_i <= '0;
    edge_to_i <= '0;
    edge_cost_i <= '0;
    source_node_i <= '0;
    node_count_we_i <= 1'b0;
    node_count_i <= '0;
    edge_count = 0;
    nodes_in_use = NODE_COUNT_RESET;
    error_count = 0;
    requests_accepted = 0;
    runs_accepted = 0;
    reports_checked = 0;
    settings_written = 0;
    sender_idle_pct = 27;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_small_graph();
    test_negative_cycle();
    test_node_count_limits();
    test_random_traffic(27, 40, 8);
    test_random_traffic(70, 40, 16);
    test_random_traffic(0, 40, 12);

    start <= 1'b0;
    for (int w = 0; w < 500000 && expected_nodes.size() != 0; w++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (expected_nodes.size() != 0) begin
      note_error($sformatf("%0d node reports never arrived", expected_nodes.size()));
    end

    $display("tb: %0d requests accepted, %0d of them path runs, %0d node reports checked",
             requests_accepted, runs_accepted, reports_checked);
    $display("tb: %0d node count settings written, %0d errors", settings_written,
             error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bfsp_pkg.sv
sv/bfsp_ram.sv
sv/bellman_ford_shortest_paths_unit.sv
tb/sv/testbench.sv
